/* design/cer_pkg.sv */
package cer_pkg;

	localparam int NUM_COLUMNS = 1024;
	localparam int COL_W = 10;

	localparam logic [1:0] REG_ORIGIN_X = 2'd0;
	localparam logic [1:0] REG_SAMPLE_STEP = 2'd1;
	localparam logic [1:0] REG_INVERSE_STEP = 2'd2;

	typedef enum logic [1:0] {
		OP_MUL = 2'd0,
		OP_DIV = 2'd1,
		OP_SQRT = 2'd2
	} alu_op_t;

	typedef struct packed {
		logic start;
		alu_op_t op;
	} alu_req_t;

endpackage

/* design/cer_alu.sv */
module cer_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  cer_pkg::alu_req_t req,
	input  logic [67:0]       opa,
	input  logic [33:0]       opb,
	output logic              done,
	output logic [67:0]       result,
	output logic              rem_nz
);

	cer_pkg::alu_op_t op_q;
	logic        busy_q;
	logic        done_q;
	logic [6:0]  cnt_q;
	logic [67:0] a_q;
	logic [67:0] b_q;
	logic [67:0] acc_q;
	logic [37:0] r_q;
	logic [33:0] d_q;

	logic [34:0] div_r;
	logic [37:0] sq_r;
	logic [37:0] sq_trial;

	assign div_r = {r_q[33:0], b_q[67]};
	assign sq_r = {r_q[35:0], b_q[67:66]};
	assign sq_trial = {2'b00, acc_q[33:0], 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			op_q <= cer_pkg::OP_MUL;
		end else begin
			done_q <= !req.start && busy_q && (cnt_q == 7'd1);
			if (req.start) begin
				busy_q <= 1'b1;
				op_q <= req.op;
				cnt_q <= (req.op == cer_pkg::OP_DIV) ? 7'd68 : 7'd34;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			r_q <= '0;
			d_q <= opb;
			case (req.op)
				cer_pkg::OP_MUL: begin
					a_q <= {34'd0, opa[33:0]};
					b_q <= {34'd0, opb};
				end
				default: begin
					a_q <= '0;
					b_q <= opa;
				end
			endcase
		end else if (busy_q) begin
			case (op_q)
				cer_pkg::OP_MUL: begin
					if (b_q[0])
						acc_q <= acc_q + a_q;
					a_q <= {a_q[66:0], 1'b0};
					b_q <= {1'b0, b_q[67:1]};
				end
				cer_pkg::OP_DIV: begin
					if (div_r >= {1'b0, d_q}) begin
						r_q <= {3'b000, div_r - {1'b0, d_q}};
						acc_q <= {acc_q[66:0], 1'b1};
					end else begin
						r_q <= {3'b000, div_r};
						acc_q <= {acc_q[66:0], 1'b0};
					end
					b_q <= {b_q[66:0], 1'b0};
				end
				cer_pkg::OP_SQRT: begin
					if (sq_r >= sq_trial) begin
						r_q <= sq_r - sq_trial;
						acc_q <= {acc_q[66:0], 1'b1};
					end else begin
						r_q <= sq_r;
						acc_q <= {acc_q[66:0], 1'b0};
					end
					b_q <= {b_q[65:0], 2'b00};
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end
	end

	assign done = done_q;
	assign result = acc_q;
	assign rem_nz = (r_q != '0);

endmodule

/* design/column_envelope_rasterizer.sv */
// Column envelope rasterizer: edge beats (kind 0) are sampled along their length, and the
// first and last sample of each column run widen that column's lowest and highest y; read
// beats (kind 1) return one column and clear it. After reset the column memory is cleared
// before the first beat is taken. A read beat reads the memory and works out point_x, then
// presents the column once the output is free. An edge beat runs on one shared shift-add
// multiplier, restoring divider and square-root unit: setup (two squares, the root and the
// sample count division), then roughly (columns crossed + 1) * (log2(samples) + 1) column
// probes, and for every column touched two y evaluations plus a column update each. No
// beat is taken while an edge or a read is in work.
module column_envelope_rasterizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [31:0] start_x,
	input  logic [31:0] start_y,
	input  logic [31:0] end_x,
	input  logic [31:0] end_y,
	input  logic [9:0]  column_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] point_x,
	output logic [31:0] low_y,
	output logic [31:0] high_y,
	output logic        occupied,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic [19:0] {
		S_CLEAR   = 20'h00001,
		S_IDLE    = 20'h00002,
		S_RD_MEM  = 20'h00004,
		S_RD_OUT  = 20'h00008,
		S_SQX     = 20'h00010,
		S_SQY     = 20'h00020,
		S_SQRT    = 20'h00040,
		S_NDIV    = 20'h00080,
		S_KSTART  = 20'h00100,
		S_K_GOT   = 20'h00200,
		S_BS_TEST = 20'h00400,
		S_BS_GOT  = 20'h00800,
		S_EV_M    = 20'h01000,
		S_EV_P    = 20'h02000,
		S_EV_D    = 20'h04000,
		S_EV_POST = 20'h08000,
		S_EV_R    = 20'h10000,
		S_MARK_RD = 20'h20000,
		S_MARK_WR = 20'h40000,
		S_NEXT    = 20'h80000
	} state_t;

	state_t state_q, ret_q, last_q;
	logic        go;
	logic [10:0] clr_q;
	logic [31:0] origin_q;
	logic [30:0] step_q;
	logic [30:0] inv_q;
	logic [31:0] x1_q, y1_q;
	logic [32:0] dx_q, dy_q;
	logic [67:0] sq_q;
	logic [33:0] len_q, n_q, k_q, lo_q, hi_q, mid_q, idx_q, m_q;
	logic        evy_q, second_q;
	logic [34:0] off_q;
	logic [32:0] v_q;
	logic [11:0] cur_q, rgn_q;
	logic [31:0] yv_q;
	logic [9:0]  col_q;
	logic [31:0] px_q;
	logic        out_valid_q;
	logic [31:0] point_x_q, low_y_q, high_y_q;
	logic        occupied_q;

	logic [64:0] mem_q [cer_pkg::NUM_COLUMNS];
	logic [64:0] rdata_q;
	logic        mem_we, mem_re;
	logic [9:0]  mem_waddr, mem_raddr;
	logic [64:0] mem_wdata;

	cer_pkg::alu_req_t alu_req;
	logic [67:0] alu_opa, alu_result;
	logic [33:0] alu_opb;
	logic        alu_done, alu_rem_nz;

	logic [30:0] step_eff;
	logic [32:0] dx_mag, dy_mag, d_mag, v_mag;
	logic        d_neg;
	logic [31:0] base;
	logic [34:0] off_div, val;
	logic [34:0] span;
	logic [33:0] mid;
	logic [31:0] cquo;
	logic [11:0] region;
	logic [40:0] px_prod;
	logic [42:0] px_sum;
	logic        cfg_wr, in_take, out_free;
	logic        used;
	logic [31:0] old_min, old_max, new_min, new_max;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign in_stall = (state_q != S_IDLE);
	assign in_take = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// The shared unit starts on the first cycle of every state that uses it.
	assign go = (state_q != last_q) && (state_q inside {S_SQX, S_SQY, S_SQRT, S_NDIV,
		S_EV_M, S_EV_P, S_EV_D, S_EV_R});

	always_comb begin
		case (paddr[3:2])
			cer_pkg::REG_ORIGIN_X: prdata = origin_q;
			cer_pkg::REG_SAMPLE_STEP: prdata = {1'b0, step_q};
			cer_pkg::REG_INVERSE_STEP: prdata = {1'b0, inv_q};
			default: prdata = '0;
		endcase
	end

	assign step_eff = (step_q == '0) ? 31'd1 : step_q;
	assign dx_mag = dx_q[32] ? (33'd0 - dx_q) : dx_q;
	assign dy_mag = dy_q[32] ? (33'd0 - dy_q) : dy_q;
	assign d_mag = evy_q ? dy_mag : dx_mag;
	assign d_neg = evy_q ? dy_q[32] : dx_q[32];
	assign v_mag = v_q[32] ? (33'd0 - v_q) : v_q;
	assign base = evy_q ? y1_q : x1_q;

	// Floor of the signed quotient: a negative distance with a remainder rounds down once more.
	assign off_div = d_neg ? (35'd0 - {1'b0, alu_result[33:0]} - {34'd0, alu_rem_nz})
		: {1'b0, alu_result[33:0]};
	assign val = {{3{base[31]}}, base} + off_q;

	assign span = {1'b0, hi_q} - {1'b0, lo_q} + 35'd1;
	assign mid = lo_q + span[34:1];

	assign cquo = alu_result[63:32];
	always_comb begin
		if (v_q[32])
			region = (cquo == '0) ? 12'd0 : 12'hFFF;
		else if (cquo >= 32'(cer_pkg::NUM_COLUMNS))
			region = 12'(cer_pkg::NUM_COLUMNS);
		else
			region = {2'b00, cquo[9:0]};
	end

	assign px_prod = {31'd0, col_q} * {10'd0, step_q};
	assign px_sum = {{11{origin_q[31]}}, origin_q} + {2'b00, px_prod};

	assign used = rdata_q[64];
	assign old_min = rdata_q[63:32];
	assign old_max = rdata_q[31:0];
	assign new_min = (!used || ($signed(yv_q) < $signed(old_min))) ? yv_q : old_min;
	assign new_max = (!used || ($signed(yv_q) > $signed(old_max))) ? yv_q : old_max;

	always_comb begin
		alu_req.start = go;
		alu_req.op = cer_pkg::OP_MUL;
		alu_opa = '0;
		alu_opb = '0;
		case (state_q)
			S_SQX: begin
				alu_opa = {35'd0, dx_mag};
				alu_opb = {1'b0, dx_mag};
			end
			S_SQY: begin
				alu_opa = {35'd0, dy_mag};
				alu_opb = {1'b0, dy_mag};
			end
			S_SQRT: begin
				alu_req.op = cer_pkg::OP_SQRT;
				alu_opa = sq_q + alu_result;
			end
			S_NDIV: begin
				alu_req.op = cer_pkg::OP_DIV;
				alu_opa = {34'd0, len_q - 34'd1};
				alu_opb = {3'b000, step_eff};
			end
			S_EV_M: begin
				alu_opa = {34'd0, idx_q};
				alu_opb = {3'b000, step_eff};
			end
			S_EV_P: begin
				alu_opa = {35'd0, d_mag};
				alu_opb = m_q;
			end
			S_EV_D: begin
				alu_req.op = cer_pkg::OP_DIV;
				alu_opa = alu_result;
				alu_opb = len_q;
			end
			S_EV_R: begin
				alu_opa = {35'd0, v_mag};
				alu_opb = {3'b000, inv_q};
			end
			default: begin
				alu_req.start = go;
			end
		endcase
	end

	cer_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.opa    (alu_opa),
		.opb    (alu_opb),
		.done   (alu_done),
		.result (alu_result),
		.rem_nz (alu_rem_nz)
	);

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = rgn_q[9:0];
		mem_wdata = {1'b1, new_min, new_max};
		mem_re = 1'b0;
		mem_raddr = rgn_q[9:0];
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				mem_waddr = clr_q[9:0];
				mem_wdata = '0;
			end
			S_RD_MEM: begin
				mem_re = 1'b1;
				mem_raddr = col_q;
			end
			S_RD_OUT: begin
				mem_we = out_free && used;
				mem_waddr = col_q;
				mem_wdata = {1'b0, rdata_q[63:0]};
			end
			S_MARK_RD: begin
				mem_re = 1'b1;
			end
			S_MARK_WR: begin
				mem_we = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem_q[mem_waddr] <= mem_wdata;
		if (mem_re)
			rdata_q <= mem_q[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q <= '0;
			step_q <= 31'd65536;
			inv_q <= 31'd65536;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				cer_pkg::REG_ORIGIN_X: origin_q <= pwdata;
				cer_pkg::REG_SAMPLE_STEP: step_q <= pwdata[30:0];
				cer_pkg::REG_INVERSE_STEP: inv_q <= pwdata[30:0];
				default: origin_q <= origin_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			last_q <= S_CLEAR;
			ret_q <= S_IDLE;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			last_q <= state_q;
			if (out_valid_q && !out_stall && (state_q != S_RD_OUT))
				out_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 11'd1;
					if (clr_q == 11'(cer_pkg::NUM_COLUMNS - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_take) begin
						if (kind) begin
							col_q <= column_index;
							state_q <= S_RD_MEM;
						end else begin
							x1_q <= start_x;
							y1_q <= start_y;
							dx_q <= {end_x[31], end_x} - {start_x[31], start_x};
							dy_q <= {end_y[31], end_y} - {start_y[31], start_y};
							state_q <= S_SQX;
						end
					end
				end
				S_RD_MEM: begin
					if ($signed(px_sum) > $signed(43'sh7FFFFFFF))
						px_q <= 32'h7FFFFFFF;
					else if ($signed(px_sum) < -$signed(43'sh80000000))
						px_q <= 32'h80000000;
					else
						px_q <= px_sum[31:0];
					state_q <= S_RD_OUT;
				end
				S_RD_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						point_x_q <= px_q;
						occupied_q <= used;
						low_y_q <= used ? old_min : 32'd0;
						high_y_q <= used ? old_max : 32'd0;
						state_q <= S_IDLE;
					end
				end
				S_SQX: begin
					if (alu_done) begin
						sq_q <= alu_result;
						state_q <= S_SQY;
					end
				end
				S_SQY: begin
					if (alu_done)
						state_q <= S_SQRT;
				end
				S_SQRT: begin
					if (alu_done) begin
						len_q <= alu_result[33:0];
						k_q <= '0;
						if (alu_result[33:0] == '0) begin
							n_q <= 34'd1;
							state_q <= S_KSTART;
						end else begin
							state_q <= S_NDIV;
						end
					end
				end
				S_NDIV: begin
					if (alu_done) begin
						n_q <= alu_result[33:0] + 34'd1;
						state_q <= S_KSTART;
					end
				end
				S_KSTART: begin
					idx_q <= k_q;
					evy_q <= 1'b0;
					ret_q <= S_K_GOT;
					state_q <= S_EV_M;
				end
				S_K_GOT: begin
					rgn_q <= cur_q;
					lo_q <= k_q;
					hi_q <= n_q - 34'd1;
					state_q <= S_BS_TEST;
				end
				S_BS_TEST: begin
					if (lo_q < hi_q) begin
						mid_q <= mid;
						idx_q <= mid;
						evy_q <= 1'b0;
						ret_q <= S_BS_GOT;
						state_q <= S_EV_M;
					end else if (rgn_q[11:10] == 2'b00) begin
						second_q <= 1'b0;
						idx_q <= k_q;
						evy_q <= 1'b1;
						ret_q <= S_MARK_RD;
						state_q <= S_EV_M;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_BS_GOT: begin
					if (cur_q == rgn_q)
						lo_q <= mid_q;
					else
						hi_q <= mid_q - 34'd1;
					state_q <= S_BS_TEST;
				end
				S_EV_M: begin
					if (alu_done) begin
						m_q <= alu_result[33:0];
						if (alu_result[33:0] == '0) begin
							off_q <= '0;
							state_q <= S_EV_POST;
						end else begin
							state_q <= S_EV_P;
						end
					end
				end
				S_EV_P: begin
					if (alu_done)
						state_q <= S_EV_D;
				end
				S_EV_D: begin
					if (alu_done) begin
						off_q <= off_div;
						state_q <= S_EV_POST;
					end
				end
				S_EV_POST: begin
					if (evy_q) begin
						yv_q <= val[31:0];
						state_q <= ret_q;
					end else begin
						v_q <= {val[31], val[31:0]} - {origin_q[31], origin_q};
						state_q <= S_EV_R;
					end
				end
				S_EV_R: begin
					if (alu_done) begin
						cur_q <= region;
						state_q <= ret_q;
					end
				end
				S_MARK_RD: begin
					state_q <= S_MARK_WR;
				end
				S_MARK_WR: begin
					if (!second_q) begin
						second_q <= 1'b1;
						idx_q <= lo_q;
						evy_q <= 1'b1;
						ret_q <= S_MARK_RD;
						state_q <= S_EV_M;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					if (lo_q >= n_q - 34'd1) begin
						state_q <= S_IDLE;
					end else begin
						k_q <= lo_q + 34'd1;
						state_q <= S_KSTART;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign point_x = point_x_q;
	assign low_y = low_y_q;
	assign high_y = high_y_q;
	assign occupied = occupied_q;

endmodule

/* tb/tb_column_envelope_rasterizer.sv */
module tb_column_envelope_rasterizer;

	localparam longint CYCLE_LIMIT = 60000000;
	localparam int HOLD_CYCLES = 3000;
	localparam longint ONE = 65536;

	typedef struct packed {
		logic [31:0] px;
		logic [31:0] lo;
		logic [31:0] hi;
		logic        occ;
	} column_rd_t;

	typedef struct {
		bit          k;
		logic [31:0] sx, sy, ex, ey;
		logic [9:0]  ci;
		bit          typed;
		column_rd_t  r;
	} dir_row_t;

	logic        clk, arst_n;
	logic        in_valid, in_stall, kind;
	logic [31:0] start_x, start_y, end_x, end_y;
	logic [9:0]  column_index;
	logic        out_valid, out_stall, occupied;
	logic [31:0] point_x, low_y, high_y;
	logic        psel, penable, pwrite, pready;
	logic [3:0]  paddr;
	logic [31:0] pwdata, prdata;

	column_envelope_rasterizer DUT (.*);

	// Model state of the column store and the registers.
	longint          cfg_org;
	longint unsigned cfg_step, cfg_inv;
	longint          col_lo [cer_pkg::NUM_COLUMNS];
	longint          col_hi [cer_pkg::NUM_COLUMNS];
	bit              col_used [cer_pkg::NUM_COLUMNS];

	column_rd_t pending_reads[$];
	dir_row_t   dir_rows[$];
	int         mismatches = 0;
	int         beats_sent = 0;
	int         reads_checked = 0;
	int         occupied_seen = 0;
	longint     cycles = 0;
	int         hold_ticket = 0;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("%0t: timeout after %0d cycles, %0d reads still pending", $time, cycles,
			pending_reads.size());
		$display("FAIL");
		$finish;
	end

	function automatic longint unsigned mag(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint unsigned isqrt(logic [127:0] n);
		logic [63:0] r, c;
		r = 0;
		for (int b = 62; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if (128'(c) * 128'(c) <= n)
				r = c;
		end
		return r;
	endfunction

	// floor(d * m / len), rounded toward minus infinity.
	function automatic longint frac_offset(longint d, longint unsigned m, longint unsigned len);
		logic [127:0] p, q, r;
		if (len == 0 || m == 0 || d == 0)
			return 0;
		p = 128'(mag(d)) * 128'(m);
		q = p / 128'(len);
		r = p % 128'(len);
		if (d < 0)
			return -longint'(q[63:0]) - ((r != 0) ? 1 : 0);
		return longint'(q[63:0]);
	endfunction

	// -1 left of the grid, NUM_COLUMNS right of it, else the column.
	function automatic longint column_of(longint x);
		longint v, c, col;
		logic [127:0] p;
		v = x - cfg_org;
		p = 128'(mag(v)) * 128'(cfg_inv);
		c = longint'(p[95:32]);
		col = v < 0 ? -c : c;
		if (col < 0)
			return -1;
		if (col >= cer_pkg::NUM_COLUMNS)
			return cer_pkg::NUM_COLUMNS;
		return col;
	endfunction

	function automatic void widen_column(longint col, longint y);
		if (col < 0 || col >= cer_pkg::NUM_COLUMNS)
			return;
		if (!col_used[col]) begin
			col_used[col] = 1;
			col_lo[col] = y;
			col_hi[col] = y;
		end else begin
			if (y < col_lo[col]) col_lo[col] = y;
			if (y > col_hi[col]) col_hi[col] = y;
		end
	endfunction

	// Walks the samples one column run at a time; both ends of each run are marked.
	function automatic void rasterize_segment(longint x1, longint y1, longint x2, longint y2);
		longint dx, dy, r;
		longint unsigned st, len, n, k, lo, hi, mid;
		dx = x2 - x1;
		dy = y2 - y1;
		st = (cfg_step != 0) ? cfg_step : 1;
		len = isqrt(128'(mag(dx)) * 128'(mag(dx)) + 128'(mag(dy)) * 128'(mag(dy)));
		n = (len == 0) ? 1 : (len - 1) / st + 1;
		k = 0;
		forever begin
			r = column_of(x1 + frac_offset(dx, k * st, len));
			lo = k;
			hi = n - 1;
			while (lo < hi) begin
				mid = lo + (hi - lo + 1) / 2;
				if (column_of(x1 + frac_offset(dx, mid * st, len)) == r)
					lo = mid;
				else
					hi = mid - 1;
			end
			if (r >= 0 && r < cer_pkg::NUM_COLUMNS) begin
				widen_column(r, y1 + frac_offset(dy, k * st, len));
				widen_column(r, y1 + frac_offset(dy, lo * st, len));
			end
			if (lo >= n - 1)
				break;
			k = lo + 1;
		end
	endfunction

	function automatic column_rd_t read_column(logic [9:0] idx);
		column_rd_t res;
		longint px;
		px = longint'(idx) * longint'(cfg_step) + cfg_org;
		if (px > 64'sh7FFFFFFF) px = 64'sh7FFFFFFF;
		if (px < -64'sh80000000) px = -64'sh80000000;
		res.px = px[31:0];
		res.lo = 0;
		res.hi = 0;
		res.occ = 0;
		if (col_used[idx]) begin
			res.lo = col_lo[idx][31:0];
			res.hi = col_hi[idx][31:0];
			res.occ = 1;
			col_used[idx] = 0;
		end
		return res;
	endfunction

	always @(posedge clk) begin
		column_rd_t want;
		if (out_valid && !out_stall) begin
			if (pending_reads.size() == 0) begin
				$display("%0t: unexpected result point_x %h low_y %h high_y %h occupied %b",
					$time, point_x, low_y, high_y, occupied);
				mismatches++;
			end else begin
				want = pending_reads.pop_front();
				reads_checked++;
				if (occupied) occupied_seen++;
				if (point_x !== want.px) begin
					$display("%0t: point_x expected %h actual %h", $time, want.px, point_x);
					mismatches++;
				end
				if (low_y !== want.lo) begin
					$display("%0t: low_y expected %h actual %h", $time, want.lo, low_y);
					mismatches++;
				end
				if (high_y !== want.hi) begin
					$display("%0t: high_y expected %h actual %h", $time, want.hi, high_y);
					mismatches++;
				end
				if (occupied !== want.occ) begin
					$display("%0t: occupied expected %b actual %b", $time, want.occ, occupied);
					mismatches++;
				end
			end
		end
	end

	// Receiver: random stall bursts with quiet stretches, plus a long hold-off on request.
	initial begin
		int burst, free, seen, hold;
		burst = 0;
		free = 0;
		seen = 0;
		hold = 0;
		out_stall = 0;
		forever begin
			@(negedge clk);
			if (seen != hold_ticket) begin
				seen = hold_ticket;
				hold = HOLD_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				out_stall <= 1;
			end else if (burst > 0) begin
				burst--;
				out_stall <= 1;
			end else if (free > 0) begin
				free--;
				out_stall <= 0;
			end else begin
				burst = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(10, 80);
				free = ($urandom_range(0, 99) < 20) ? $urandom_range(50, 300) : $urandom_range(0, 8);
				out_stall <= 0;
			end
		end
	end

	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1;
		pwrite <= 1;
		penable <= 0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (idx)
			cer_pkg::REG_ORIGIN_X:     cfg_org = longint'($signed(val));
			cer_pkg::REG_SAMPLE_STEP:  cfg_step = val[30:0];
			cer_pkg::REG_INVERSE_STEP: cfg_inv = val[30:0];
			default: ;
		endcase
	endtask

	task automatic send_beat(bit k, logic [31:0] sx, sy, ex, ey, logic [9:0] ci,
		bit typed, column_rd_t tv);
		int gap, r;
		column_rd_t res;
		r = $urandom_range(0, 99);
		gap = (r < 65) ? 0 : (r < 93) ? $urandom_range(1, 3) : $urandom_range(10, 60);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1;
		kind <= k;
		start_x <= sx;
		start_y <= sy;
		end_x <= ex;
		end_y <= ey;
		column_index <= ci;
		do @(posedge clk); while (in_stall);
		beats_sent++;
		if (k) begin
			res = read_column(ci);
			if (typed)
				res = tv;
			pending_reads = {pending_reads, res};
		end else begin
			rasterize_segment(longint'($signed(sx)), longint'($signed(sy)),
				longint'($signed(ex)), longint'($signed(ey)));
		end
	endtask

	// A closing read follows any edge still in work, so the drain covers the whole phase.
	task automatic close_phase();
		send_beat(1'b1, $urandom, $urandom, $urandom, $urandom, 10'($urandom_range(0, 1023)),
			1'b0, '0);
		@(negedge clk);
		in_valid <= 0;
		while (pending_reads.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [31:0] clamp32(longint v);
		if (v > 64'sh7FFFFFFF) return 32'h7FFFFFFF;
		if (v < -64'sh80000000) return 32'h80000000;
		return v[31:0];
	endfunction

	// cw is the column width in raw units and base the grid origin; edges stay a few
	// columns wide so that the block's per-column probing keeps the run short.
	task automatic random_beat(longint cw, longint base, bit full);
		longint x1, y1, dxv, dyv;
		int sel;
		logic [9:0] ci;
		if ($urandom_range(0, 1)) begin
			ci = 10'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 70)
				: $urandom_range(0, 1023));
			send_beat(1'b1, $urandom, $urandom, $urandom, $urandom, ci, 1'b0, '0);
		end else if (full) begin
			send_beat(1'b0, $urandom, $urandom, $urandom, $urandom, 10'($urandom), 1'b0, '0);
		end else begin
			sel = $urandom_range(0, 99);
			x1 = base - 4 * cw + longint'($urandom_range(0, int'(cw - 1)))
				+ longint'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 1030)
				: $urandom_range(0, 70)) * cw;
			dxv = (sel < 20) ? 0 : longint'($urandom_range(0, int'(6 * cw))) - 3 * cw;
			if ($urandom_range(0, 4) == 0) begin
				y1 = longint'($signed($urandom));
				dyv = longint'($signed($urandom)) - y1;
			end else begin
				y1 = longint'($urandom_range(0, 128 * ONE)) - 64 * ONE;
				dyv = longint'($urandom_range(0, 128 * ONE)) - 64 * ONE;
			end
			if (sel < 5)
				dyv = 0;
			send_beat(1'b0, clamp32(x1), clamp32(y1), clamp32(x1 + dxv), clamp32(y1 + dyv),
				10'($urandom), 1'b0, '0);
		end
	endtask

	function automatic void add_row(bit k, logic [31:0] sx, sy, ex, ey, logic [9:0] ci,
		bit typed, column_rd_t r);
		dir_row_t d;
		d.k = k;
		d.sx = sx;
		d.sy = sy;
		d.ex = ex;
		d.ey = ey;
		d.ci = ci;
		d.typed = typed;
		d.r = r;
		dir_rows = {dir_rows, d};
	endfunction

	initial begin
		longint st;
		in_valid = 0;
		kind = 0;
		start_x = 0;
		start_y = 0;
		end_x = 0;
		end_y = 0;
		column_index = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		arst_n = 0;
		cfg_org = 0;
		cfg_step = ONE;
		cfg_inv = ONE;
		foreach (col_used[i]) begin
			col_used[i] = 0;
			col_lo[i] = 0;
			col_hi[i] = 0;
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		reg_write(cer_pkg::REG_ORIGIN_X, 32'd0);
		reg_write(cer_pkg::REG_SAMPLE_STEP, 32'h10000);
		reg_write(cer_pkg::REG_INVERSE_STEP, 32'h10000);

		// Reads after reset, a point edge, the column just left of the grid origin,
		// far-off vertical edges at the coordinate extremes, and both end columns.
		add_row(1'b1, 0, 0, 0, 0, 10'd0, 1'b1, '{32'd0, 32'd0, 32'd0, 1'b0});
		add_row(1'b1, 0, 0, 0, 0, 10'd1023, 1'b1, '{32'd67043328, 32'd0, 32'd0, 1'b0});
		add_row(1'b0, 32'h00058000, 32'hFFFD0000, 32'h00058000, 32'hFFFD0000, 10'd0, 1'b0, '0);
		add_row(1'b1, 0, 0, 0, 0, 10'd5, 1'b1,
			'{32'd327680, 32'hFFFD0000, 32'hFFFD0000, 1'b1});
		add_row(1'b1, 0, 0, 0, 0, 10'd5, 1'b1, '{32'd327680, 32'd0, 32'd0, 1'b0});
		add_row(1'b0, 32'hFFFF8000, 32'h00070000, 32'hFFFFC000, 32'h00090000, 10'd0, 1'b0, '0);
		add_row(1'b1, 0, 0, 0, 0, 10'd0, 1'b0, '0);
		add_row(1'b0, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 10'd0, 1'b0, '0);
		add_row(1'b0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 10'd0, 1'b0, '0);
		add_row(1'b0, 32'h0, 32'h0, 32'h00030000, 32'h00030000, 10'd0, 1'b0, '0);
		for (int c = 0; c < 4; c++)
			add_row(1'b1, 0, 0, 0, 0, 10'(c), 1'b0, '0);
		add_row(1'b0, 32'h03FF8000, 32'h00010000, 32'h03FF8000, 32'hFFFF0000, 10'd0, 1'b0, '0);
		add_row(1'b1, 0, 0, 0, 0, 10'd1023, 1'b0, '0);
		add_row(1'b0, 32'h07D00000, 32'h00050000, 32'h07E00000, 32'h00060000, 10'd0, 1'b0, '0);
		foreach (dir_rows[i])
			send_beat(dir_rows[i].k, dir_rows[i].sx, dir_rows[i].sy, dir_rows[i].ex,
				dir_rows[i].ey, dir_rows[i].ci, dir_rows[i].typed, dir_rows[i].r);
		close_phase();

		// Hold the results back long enough for the block to fill and stall its input.
		hold_ticket++;
		repeat (40)
			send_beat(1'b1, $urandom, $urandom, $urandom, $urandom, 10'($urandom_range(0, 70)),
				1'b0, '0);
		repeat (650)
			random_beat(ONE, 0, 0);
		close_phase();

		reg_write(cer_pkg::REG_ORIGIN_X, 32'h80000000);
		reg_write(cer_pkg::REG_SAMPLE_STEP, 32'h7FFFFFFF);
		reg_write(cer_pkg::REG_INVERSE_STEP, 32'h7FFFFFFF);
		repeat (250)
			random_beat(2, -64'sh80000000, 0);
		close_phase();

		reg_write(cer_pkg::REG_ORIGIN_X, $urandom);
		reg_write(cer_pkg::REG_SAMPLE_STEP, $urandom_range(32'h01000000, 32'h7FFFFFFF));
		reg_write(cer_pkg::REG_INVERSE_STEP, $urandom_range(1, 8));
		repeat (150)
			random_beat(ONE, 0, 1);
		close_phase();

		// Every sample lands in column zero here.
		reg_write(cer_pkg::REG_ORIGIN_X, 32'h7FFFFFFF);
		reg_write(cer_pkg::REG_SAMPLE_STEP, 32'd1);
		reg_write(cer_pkg::REG_INVERSE_STEP, 32'd1);
		repeat (100)
			random_beat(ONE, 0, 1);
		close_phase();

		st = $urandom_range(32'h4000, 32'h20000);
		reg_write(cer_pkg::REG_ORIGIN_X,
			clamp32(longint'($urandom_range(0, 200 * ONE)) - 100 * ONE));
		reg_write(cer_pkg::REG_SAMPLE_STEP, st[31:0]);
		reg_write(cer_pkg::REG_INVERSE_STEP, 32'((64'd1 << 32) / st));
		repeat (350)
			random_beat(st, cfg_org, 0);
		close_phase();

		$display("%0d beats over five register settings, %0d column reads checked, %0d occupied",
			beats_sent, reads_checked, occupied_seen);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
